FILE: design/pfde_pkg.sv
package pfde_pkg;

    // Default geometry
    localparam int DEF_COLUMNS = 128;
    localparam int DEF_PAGES   = 8;

    // Command codes
    localparam logic [2:0] CMD_CLEAR_AREA = 3'd0;
    localparam logic [2:0] CMD_BLIT_BYTE  = 3'd1;
    localparam logic [2:0] CMD_SET_PIXEL  = 3'd2;
    localparam logic [2:0] CMD_GET_PIXEL  = 3'd3;
    localparam logic [2:0] CMD_READ_BYTE  = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture a new command
        logic sweep_wr;   // write zero at the sweep address
        logic rd_en;      // issue a store read
        logic wr_en;      // write back the modified byte
        logic capture;    // latch read data into the result
        logic advance;    // step to the next page / column
        logic clip_load;  // latch the clip flag
    } t_dp_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic empty;       // command touches no store byte
        logic last;        // current byte is the final one
        logic is_write;    // command modifies the store
        logic sweep_last;  // sweep reached the final address
    } t_dp_status;

endpackage

FILE: design/pfde_ctrl.sv
module pfde_ctrl import pfde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    output logic       o_done,
    output t_dp_ctrl   o_ctrl,
    input  t_dp_status i_status
);

    localparam logic [2:0] S_SWEEP  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ACCESS = 3'd2;
    localparam logic [2:0] S_MODIFY = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register; reset starts the store clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_SWEEP: begin
                o_ctrl.sweep_wr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_ACCESS;
                end
            end
            S_ACCESS: begin
                o_ctrl.clip_load = 1'b1;
                if (i_status.empty) begin
                    n_state = S_FIN;
                end else begin
                    o_ctrl.rd_en = 1'b1;
                    n_state      = S_MODIFY;
                end
            end
            S_MODIFY: begin
                if (i_status.is_write) begin
                    o_ctrl.wr_en   = 1'b1;
                    o_ctrl.advance = 1'b1;
                    n_state        = i_status.last ? S_FIN : S_ACCESS;
                end else begin
                    o_ctrl.capture = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_FIN);

endmodule

FILE: design/pfde_dpath.sv
module pfde_dpath import pfde_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_ctrl   i_ctrl,
    output t_dp_status o_status,
    input  logic [2:0] i_cmd,
    input  logic [6:0] i_x,
    input  logic [5:0] i_y,
    input  logic [7:0] i_width,
    input  logic [6:0] i_height,
    input  logic [7:0] i_pixel_data,
    output logic [7:0] o_read_data,
    output logic       o_clipped
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = CW + PW;
    localparam int DEPTH = 1 << AW;
    localparam logic [8:0] COLS_V  = 9'(COLUMNS);
    localparam logic [4:0] PAGES_V = 5'(PAGES);
    localparam logic [7:0] ROWS_V  = 8'(PAGES * 8);

    // Captured command
    logic [2:0] r_cmd;
    logic [6:0] r_x;
    logic [5:0] r_y;
    logic [7:0] r_w;
    logic [6:0] r_h;
    logic [7:0] r_data;

    // Walk position and result
    logic [8:0]    r_col;
    logic [3:0]    r_page;
    logic [AW-1:0] r_sweep;
    logic [7:0]    r_rd;
    logic          r_clip;

    // Frame store
    logic [7:0]    mem [0:DEPTH-1];
    logic [7:0]    r_rdata;
    logic [AW-1:0] acc_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // Decode
    logic       is_clear, is_blit, is_set, is_get, is_read;
    logic [3:0] hh;
    logic [7:0] yend;
    logic [7:0] ylim;
    logic [7:0] ylast;
    logic [8:0] xend;
    logic [8:0] cend;
    logic [3:0] pg_first;
    logic [3:0] pg_next;
    logic [3:0] pl_clear;
    logic [3:0] pl_blit;
    logic [3:0] pg_last;
    logic [15:0] shifted;
    logic [7:0] upper, lower;
    logic       x_oob, pf_oob, pn_oob;
    logic       clip, empty;
    logic [7:0] mask;
    logic [7:0] or_val;
    logic [6:0] row;

    assign is_clear = (r_cmd == CMD_CLEAR_AREA);
    assign is_blit  = (r_cmd == CMD_BLIT_BYTE);
    assign is_set   = (r_cmd == CMD_SET_PIXEL);
    assign is_get   = (r_cmd == CMD_GET_PIXEL);
    assign is_read  = (r_cmd == CMD_READ_BYTE);

    // Row and column limits
    assign hh       = (r_h > 7'd8) ? 4'd8 : r_h[3:0];
    assign yend     = is_clear ? ({2'b0, r_y} + {1'b0, r_h}) : ({2'b0, r_y} + {4'b0, hh});
    assign ylim     = (yend > ROWS_V) ? ROWS_V : yend;
    assign ylast    = ylim - 8'd1;
    assign xend     = {2'b0, r_x} + {1'b0, r_w};
    assign cend     = (xend > COLS_V) ? COLS_V : xend;
    assign pg_first = {1'b0, r_y[5:3]};
    assign pg_next  = pg_first + 4'd1;
    assign pl_clear = ylast[6:3];
    assign pl_blit  = ({1'b0, pg_next} < PAGES_V) ? pg_next : pg_first;
    assign pg_last  = is_clear ? pl_clear : (is_blit ? pl_blit : pg_first);

    assign x_oob  = ({2'b0, r_x} >= COLS_V);
    assign pf_oob = ({1'b0, pg_first} >= PAGES_V);
    assign pn_oob = ({1'b0, pg_next} >= PAGES_V);

    // Blit image split across two pages
    assign shifted = {8'b0, r_data} << r_y[2:0];
    assign upper   = shifted[7:0];
    assign lower   = shifted[15:8];

    // Clip flag and empty walk per command
    always_comb begin
        clip  = 1'b0;
        empty = 1'b1;
        case (r_cmd)
            CMD_CLEAR_AREA: begin
                if (r_w != 8'd0 && r_h != 7'd0) begin
                    clip  = (xend > COLS_V) || (yend > ROWS_V);
                    empty = x_oob || ({2'b0, r_y} >= ROWS_V);
                end
            end
            CMD_BLIT_BYTE: begin
                if (r_h != 7'd0) begin
                    if (x_oob) begin
                        clip = 1'b1;
                    end else begin
                        clip  = (yend > ROWS_V) || (pf_oob && upper != 8'd0)
                                || (pn_oob && lower != 8'd0);
                        empty = pf_oob;
                    end
                end
            end
            CMD_SET_PIXEL, CMD_GET_PIXEL, CMD_READ_BYTE: begin
                clip  = x_oob || pf_oob;
                empty = x_oob || pf_oob;
            end
            default: begin
                clip  = 1'b0;
                empty = 1'b1;
            end
        endcase
    end

    // Rows of the current page that get cleared
    always_comb begin
        mask = '0;
        row  = '0;
        for (int b = 0; b < 8; b++) begin
            row = {r_page, 3'(b)};
            mask[b] = (is_clear || is_blit) && ({1'b0, row} >= {2'b0, r_y})
                      && ({1'b0, row} < yend);
        end
    end

    always_comb begin
        or_val = 8'd0;
        if (is_blit) begin
            or_val = (r_page == pg_first) ? upper : lower;
        end else if (is_set) begin
            or_val = 8'(9'd1 << r_y[2:0]);
        end
    end

    assign o_status.empty      = empty;
    assign o_status.last       = (r_page == pg_last) && (!is_clear || (r_col + 9'd1 >= cend));
    assign o_status.is_write   = is_clear || is_blit || is_set;
    assign o_status.sweep_last = &r_sweep;

    // Hold the command fields
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_cmd;
            r_x    <= i_x;
            r_y    <= i_y;
            r_w    <= i_width;
            r_h    <= i_height;
            r_data <= i_pixel_data;
        end
    end

    // Advance the walk: pages inner, columns outer
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_col  <= {2'b0, i_x};
            r_page <= {1'b0, i_y[5:3]};
        end else if (i_ctrl.advance) begin
            if (is_clear && r_page == pg_last) begin
                r_page <= pg_first;
                r_col  <= r_col + 9'd1;
            end else begin
                r_page <= r_page + 4'd1;
            end
        end
    end

    // Sweep address for the clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_ctrl.sweep_wr) begin
            r_sweep <= r_sweep + AW'(1);
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rd <= 8'd0;
        end else if (i_ctrl.capture) begin
            if (is_get) begin
                r_rd <= {7'd0, r_rdata[r_y[2:0]]};
            end else if (is_read) begin
                r_rd <= r_rdata;
            end
        end
        if (i_ctrl.clip_load) begin
            r_clip <= clip;
        end
    end

    // Store access
    assign acc_addr = {r_page[PW-1:0], r_col[CW-1:0]};
    assign wr_addr  = i_ctrl.sweep_wr ? r_sweep : acc_addr;
    assign wr_data  = i_ctrl.sweep_wr ? 8'd0 : ((r_rdata & ~mask) | or_val);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sweep_wr || i_ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rdata <= mem[acc_addr];
        end
    end

    assign o_read_data = r_rd;
    assign o_clipped   = r_clip;

endmodule

FILE: design/page_framebuffer_draw_engine.sv
// Per touched byte a command passes ACCESS (store read) and MODIFY (write-back or result
// capture), then FIN raises the result strobe o_done; a command touching nothing goes from
// ACCESS to FIN. busy is high until IDLE returns, so a new command waits for the last one;
// one read and one write-back per byte for commands that modify the store.
// Reset (synchronous, active low) starts a clearing pass over all 2**(clog2(COLUMNS)+max(1,
// clog2(PAGES))) bytes (1024 by default) with busy high; the receiver cannot stall results.
module page_framebuffer_draw_engine import pfde_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_cmd,
    input  logic [6:0] i_x,
    input  logic [5:0] i_y,
    input  logic [7:0] i_width,
    input  logic [6:0] i_height,
    input  logic [7:0] i_pixel_data,
    output logic       o_done,
    output logic [7:0] o_read_data,
    output logic       o_clipped
);

    t_dp_ctrl   ctrl;
    t_dp_status status;

    // Sequencer
    pfde_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_done   (o_done),
        .o_ctrl   (ctrl),
        .i_status (status)
    );

    // Frame store and address walk
    pfde_dpath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_status     (status),
        .i_cmd        (i_cmd),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_width      (i_width),
        .i_height     (i_height),
        .i_pixel_data (i_pixel_data),
        .o_read_data  (o_read_data),
        .o_clipped    (o_clipped)
    );

endmodule

FILE: test/tb_page_framebuffer_draw_engine.sv
`timescale 1ns / 1ps

module tb_page_framebuffer_draw_engine;
    import pfde_pkg::*;

    localparam int COLS     = DEF_COLUMNS;
    localparam int PAGE_CNT = DEF_PAGES;
    localparam int ROW_CNT  = PAGE_CNT * 8;

    // Codes the block defines no action for
    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int STALL_LIMIT   = 12000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] read_data;
        logic       clipped;
    } t_reply;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [2:0] i_cmd;
    logic [6:0] i_x;
    logic [5:0] i_y;
    logic [7:0] i_width;
    logic [6:0] i_height;
    logic [7:0] i_pixel_data;
    logic       o_done;
    logic [7:0] o_read_data;
    logic       o_clipped;

    // Shadow copy of the frame store, index page * COLS + column
    logic [7:0] shadow_frame [COLS * PAGE_CNT];
    t_reply     replies_due [$];
    t_reply     due_reply;
    int         mismatches;
    int         idle_cycles;
    int         hot_x;
    int         hot_y;

    page_framebuffer_draw_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_x          (i_x),
        .i_y          (i_y),
        .i_width      (i_width),
        .i_height     (i_height),
        .i_pixel_data (i_pixel_data),
        .o_done       (o_done),
        .o_read_data  (o_read_data),
        .o_clipped    (o_clipped)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Apply one command to the shadow frame and return the reply it should give
    function automatic t_reply apply_draw_cmd(input logic [2:0] c, input logic [6:0] x,
                                              input logic [5:0] y, input logic [7:0] w,
                                              input logic [6:0] h, input logic [7:0] d);
        t_reply      r;
        int          xi;
        int          yi;
        int          wi;
        int          hi;
        int          rows;
        int          pg;
        logic [15:0] shifted;
        r.cmd       = c;
        r.read_data = 8'h00;
        r.clipped   = 1'b0;
        xi = int'(x);
        yi = int'(y);
        wi = int'(w);
        hi = int'(h);
        pg = yi >> 3;
        case (c)
            CMD_CLEAR_AREA: begin
                if (wi != 0 && hi != 0) begin
                    r.clipped = (xi + wi > COLS) || (yi + hi > ROW_CNT);
                    for (int col = xi; col < xi + wi && col < COLS; col++)
                        for (int row = yi; row < yi + hi && row < ROW_CNT; row++)
                            shadow_frame[(row >> 3) * COLS + col][row % 8] = 1'b0;
                end
            end
            CMD_BLIT_BYTE: begin
                if (hi != 0) begin
                    rows    = (hi > 8) ? 8 : hi;
                    shifted = {8'h00, d} << (yi % 8);
                    if (xi >= COLS) begin
                        r.clipped = 1'b1;
                    end else begin
                        if (yi + rows > ROW_CNT)
                            r.clipped = 1'b1;
                        // clear the covered rows, then merge the unmasked image byte
                        for (int row = yi; row < yi + rows && row < ROW_CNT; row++)
                            shadow_frame[(row >> 3) * COLS + xi][row % 8] = 1'b0;
                        if (pg < PAGE_CNT)
                            shadow_frame[pg * COLS + xi] |= shifted[7:0];
                        else if (shifted[7:0] != 8'h00)
                            r.clipped = 1'b1;
                        if (pg + 1 < PAGE_CNT)
                            shadow_frame[(pg + 1) * COLS + xi] |= shifted[15:8];
                        else if (shifted[15:8] != 8'h00)
                            r.clipped = 1'b1;
                    end
                end
            end
            CMD_SET_PIXEL, CMD_GET_PIXEL: begin
                if (xi >= COLS || yi >= ROW_CNT)
                    r.clipped = 1'b1;
                else if (c == CMD_SET_PIXEL)
                    shadow_frame[pg * COLS + xi][yi % 8] = 1'b1;
                else
                    r.read_data = {7'd0, shadow_frame[pg * COLS + xi][yi % 8]};
            end
            CMD_READ_BYTE: begin
                if (xi >= COLS || pg >= PAGE_CNT)
                    r.clipped = 1'b1;
                else
                    r.read_data = shadow_frame[pg * COLS + xi];
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Drive one command and hold it until the block takes the transfer
    task automatic send_draw_cmd(input logic [2:0] c, input logic [6:0] x, input logic [5:0] y,
                                 input logic [7:0] w, input logic [6:0] h, input logic [7:0] d);
        @(negedge i_clk);
        i_cmd        <= c;
        i_x          <= x;
        i_y          <= y;
        i_width      <= w;
        i_height     <= h;
        i_pixel_data <= d;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        replies_due.push_back(apply_draw_cmd(c, x, y, w, h, d));
    endtask

    // Idle the sender for a random stretch: mostly none or short, a few long
    task automatic sender_gap();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            n = 0;
        else if (sel < 85)
            n = $urandom_range(1, 3);
        else if (sel < 97)
            n = $urandom_range(4, 20);
        else
            n = $urandom_range(30, 200);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Drop start and hold off until every pending reply has come back
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input t_reply exp);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s cmd=%0d expected data=%02h clip=%0b got data=%02h clip=%0b",
                     $time, what, exp.cmd, exp.read_data, exp.clipped, o_read_data, o_clipped);
    endtask

    // Compare each result strobe with the oldest pending reply
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected result", '0);
            end else begin
                due_reply = replies_due.pop_front();
                if (o_read_data !== due_reply.read_data || o_clipped !== due_reply.clipped)
                    report_mismatch("result mismatch", due_reply);
            end
        end
    end

    // Count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic test_blank_after_reset();
        send_draw_cmd(CMD_READ_BYTE, 7'd0, 6'd0, 8'd0, 7'd0, 8'd0);
        send_draw_cmd(CMD_READ_BYTE, 7'd127, 6'd63, 8'd255, 7'd127, 8'hFF);
        send_draw_cmd(CMD_GET_PIXEL, 7'd64, 6'd37, 8'd0, 7'd0, 8'd0);
    endtask

    task automatic test_pixel_extremes();
        send_draw_cmd(CMD_SET_PIXEL, 7'd0, 6'd0, 8'd0, 7'd0, 8'd0);
        send_draw_cmd(CMD_SET_PIXEL, 7'd127, 6'd63, 8'd0, 7'd0, 8'd0);
        send_draw_cmd(CMD_SET_PIXEL, 7'd3, 6'd7, 8'd0, 7'd0, 8'd0);
        send_draw_cmd(CMD_GET_PIXEL, 7'd127, 6'd63, 8'd0, 7'd0, 8'd0);
        send_draw_cmd(CMD_GET_PIXEL, 7'd3, 6'd8, 8'd0, 7'd0, 8'd0);
        send_draw_cmd(CMD_READ_BYTE, 7'd3, 6'd0, 8'd0, 7'd0, 8'd0);
    endtask

    task automatic test_blit_cases();
        // zero height leaves the store alone
        send_draw_cmd(CMD_BLIT_BYTE, 7'd10, 6'd0, 8'd0, 7'd0, 8'hFF);
        // byte straddling two pages
        send_draw_cmd(CMD_BLIT_BYTE, 7'd10, 6'd5, 8'd0, 7'd3, 8'hA5);
        // bottom edge: rows and shifted bits fall off the screen
        send_draw_cmd(CMD_BLIT_BYTE, 7'd127, 6'd61, 8'd0, 7'd8, 8'hFF);
        // height above eight is capped
        send_draw_cmd(CMD_BLIT_BYTE, 7'd20, 6'd20, 8'd0, 7'd127, 8'h81);
        send_draw_cmd(CMD_READ_BYTE, 7'd10, 6'd8, 8'd0, 7'd0, 8'd0);
        send_draw_cmd(CMD_READ_BYTE, 7'd127, 6'd56, 8'd0, 7'd0, 8'd0);
    endtask

    task automatic test_clear_cases();
        send_draw_cmd(CMD_CLEAR_AREA, 7'd0, 6'd0, 8'd0, 7'd8, 8'd0);
        send_draw_cmd(CMD_CLEAR_AREA, 7'd0, 6'd0, 8'd8, 7'd0, 8'd0);
        // rectangle over the bottom right corner
        send_draw_cmd(CMD_CLEAR_AREA, 7'd120, 6'd60, 8'd20, 7'd10, 8'd0);
        // exactly the full screen
        send_draw_cmd(CMD_CLEAR_AREA, 7'd0, 6'd0, 8'd128, 7'd64, 8'd0);
        send_draw_cmd(CMD_CLEAR_AREA, 7'd5, 6'd3, 8'd255, 7'd127, 8'd0);
        send_draw_cmd(CMD_READ_BYTE, 7'd127, 6'd63, 8'd0, 7'd0, 8'd0);
    endtask

    task automatic test_reserved_cmds();
        send_draw_cmd(CMD_RSVD_5, 7'($urandom), 6'($urandom), 8'($urandom), 7'($urandom),
                      8'($urandom));
        send_draw_cmd(CMD_RSVD_6, 7'($urandom), 6'($urandom), 8'($urandom), 7'($urandom),
                      8'($urandom));
        send_draw_cmd(CMD_RSVD_7, 7'd127, 6'd63, 8'd255, 7'd127, 8'hFF);
    endtask

    // Mixed drawing traffic, mostly aimed at a small moving window so reads see writes
    task automatic test_random_traffic();
        int         sel;
        logic [2:0] c;
        logic [6:0] x;
        logic [5:0] y;
        logic [7:0] w;
        logic [6:0] h;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0) begin
                hot_x = $urandom_range(0, COLS - 8);
                hot_y = $urandom_range(0, ROW_CNT - 8);
            end
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 10)
                c = CMD_CLEAR_AREA;
            else if (sel < 35)
                c = CMD_BLIT_BYTE;
            else if (sel < 60)
                c = CMD_SET_PIXEL;
            else if (sel < 80)
                c = CMD_GET_PIXEL;
            else if (sel < 95)
                c = CMD_READ_BYTE;
            else begin
                case ($urandom_range(0, 2))
                    0:       c = CMD_RSVD_5;
                    1:       c = CMD_RSVD_6;
                    default: c = CMD_RSVD_7;
                endcase
            end
            if ($urandom_range(0, 9) < 7) begin
                x = 7'(hot_x + $urandom_range(0, 7));
                y = 6'(hot_y + $urandom_range(0, 7));
            end else begin
                x = 7'($urandom_range(0, 127));
                y = 6'($urandom_range(0, 63));
            end
            w = 8'($urandom_range(0, 255));
            h = 7'($urandom_range(0, 127));
            // keep most rectangles and blits small
            sel = $urandom_range(0, 99);
            if (c == CMD_CLEAR_AREA) begin
                if (sel < 80) begin
                    w = 8'($urandom_range(1, 6));
                    h = 7'($urandom_range(1, 8));
                end else if (sel < 92) begin
                    w = 8'($urandom_range(0, 40));
                    h = 7'($urandom_range(0, 24));
                end else if (sel < 97) begin
                    w = 8'($urandom_range(0, 255));
                    h = 7'($urandom_range(0, 127));
                end else begin
                    w = 8'd0;
                end
            end else if (c == CMD_BLIT_BYTE) begin
                if (sel < 75)
                    h = 7'($urandom_range(1, 8));
                else if (sel < 85)
                    h = 7'd0;
                else
                    h = 7'($urandom_range(9, 127));
            end
            send_draw_cmd(c, x, y, w, h, 8'($urandom_range(0, 255)));
            sender_gap();
        end
    endtask

    initial begin
        for (int i = 0; i < COLS * PAGE_CNT; i++)
            shadow_frame[i] = 8'h00;
        mismatches   = 0;
        idle_cycles  = 0;
        hot_x        = 0;
        hot_y        = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = CMD_CLEAR_AREA;
        i_x          = '0;
        i_y          = '0;
        i_width      = '0;
        i_height     = '0;
        i_pixel_data = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_blank_after_reset();
        test_pixel_extremes();
        test_blit_cases();
        test_clear_cases();
        test_reserved_cmds();
        wait_drained();
        test_random_traffic();
        wait_drained();

        // let any stray strobe show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
